FILE: hw/rtl/rdh_pkg.sv
// shared types and constants for the row dedup hash table
`timescale 1ns / 1ps

package rdh_pkg;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_B  = 64'h94d049bb133111eb;

    localparam int SHIFT_PRE  = 30;
    localparam int SHIFT_MID  = 27;
    localparam int SHIFT_POST = 31;

    localparam int IN_WORDS = 4;
    localparam int ID_W     = 12;
    localparam int EPOCH_W  = 8;
    localparam int WIDTH_W  = 3;

    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 3'd3;
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_MIN   = 3'd2;

    typedef logic [IN_WORDS-1:0][31:0] row_t;

    // one hashed request on its way from front to back
    typedef struct packed {
        logic               start_set;
        logic [WIDTH_W-1:0] n_words;
        row_t               words;
    } item_t;

endpackage

FILE: hw/rtl/rdh_front.sv
// front end: takes requests, hashes the row and reduces the hash to a slot
`timescale 1ns / 1ps

module rdh_front #(
    parameter int TABLE_SLOTS = 4096,
    parameter int MAX_WORDS   = 4,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rdh_pkg::WIDTH_W-1:0]   cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [127:0]                  s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          hold,
    output logic                          q_push,
    output rdh_pkg::item_t                q_item,
    output logic [SLOT_W-1:0]             q_slot,
    input  logic                          q_full
);

    localparam int RW = SLOT_W + 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MIX  = 2'd1;
    localparam logic [1:0] F_MOD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [rdh_pkg::WIDTH_W-1:0]   row_width_reg;
    logic                          start_reg, start_next;
    logic [rdh_pkg::WIDTH_W-1:0]   n_reg, n_next;
    rdh_pkg::row_t                 words_reg, words_next;
    logic [2:0]                    widx_reg, widx_next;
    logic [63:0]                   v_reg, v_next;
    logic [63:0]                   acc_reg, acc_next;
    logic [1:0]                    part_reg, part_next;
    logic                          msel_reg, msel_next;
    logic [63:0]                   hash_reg, hash_next;
    logic [RW-1:0]                 rem_reg, rem_next;

    logic [rdh_pkg::WIDTH_W-1:0]   n_cfg;
    logic [63:0]                   mconst;
    logic [31:0]                   opa, opb;
    logic [63:0]                   prod;
    logic [63:0]                   mul_r, mix_h, mix_x;
    logic [RW-1:0]                 mod_r;
    logic                          accept;

    assign s_tready = (state_reg == F_IDLE) && !hold;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (row_width_reg < rdh_pkg::ROW_WIDTH_MIN)
            n_cfg = rdh_pkg::ROW_WIDTH_MIN;
        else if (row_width_reg > rdh_pkg::WIDTH_W'(MAX_WORDS))
            n_cfg = rdh_pkg::WIDTH_W'(MAX_WORDS);
        else
            n_cfg = row_width_reg;
    end

    // one shared 32x32 multiplier, three partial products per 64-bit multiply
    assign mconst = msel_reg ? rdh_pkg::MIX_B : rdh_pkg::MIX_A;
    assign opa    = (part_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
    assign opb    = (part_reg == 2'd1) ? mconst[63:32] : mconst[31:0];
    assign prod   = {32'b0, opa} * {32'b0, opb};
    assign mul_r  = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
    assign mix_h  = mul_r ^ (mul_r >> rdh_pkg::SHIFT_POST);

    // slot from the low hash bits, wrapped once into the table range
    always_comb
    begin
        mod_r = {1'b0, hash_reg[SLOT_W-1:0]};
        if (mod_r >= RW'(TABLE_SLOTS))
            mod_r = mod_r - RW'(TABLE_SLOTS);
    end

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        n_next     = n_reg;
        words_next = words_reg;
        widx_next  = widx_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        part_next  = part_reg;
        msel_next  = msel_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        mix_x      = 64'b0;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    words_next = s_tdata;
                    start_next = s_tuser[0];
                    n_next     = n_cfg;
                    if (n_cfg == rdh_pkg::ROW_WIDTH_MIN)
                    begin
                        mix_x     = {s_tdata[31:0], s_tdata[63:32]};
                        widx_next = 3'd2;
                    end
                    else
                    begin
                        mix_x     = rdh_pkg::GOLDEN ^ {32'b0, s_tdata[31:0]};
                        widx_next = 3'd1;
                    end
                    v_next     = mix_x ^ (mix_x >> rdh_pkg::SHIFT_PRE);
                    part_next  = 2'd0;
                    msel_next  = 1'b0;
                    state_next = F_MIX;
                end
            end
            F_MIX:
            begin
                unique case (part_reg)
                    2'd0:
                    begin
                        acc_next  = prod;
                        part_next = 2'd1;
                    end
                    2'd1:
                    begin
                        acc_next  = mul_r;
                        part_next = 2'd2;
                    end
                    default:
                    begin
                        part_next = 2'd0;
                        if (!msel_reg)
                        begin
                            acc_next  = mul_r;
                            v_next    = mul_r ^ (mul_r >> rdh_pkg::SHIFT_MID);
                            msel_next = 1'b1;
                        end
                        else if (widx_reg == n_reg)
                        begin
                            hash_next  = mix_h;
                            rem_next   = '0;
                            state_next = F_MOD;
                        end
                        else
                        begin
                            mix_x     = mix_h ^ {32'b0, words_reg[widx_reg[1:0]]};
                            v_next    = mix_x ^ (mix_x >> rdh_pkg::SHIFT_PRE);
                            widx_next = widx_reg + 3'd1;
                            msel_next = 1'b0;
                        end
                    end
                endcase
            end
            F_MOD:
            begin
                rem_next   = mod_r;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                q_push = !q_full;
                if (!q_full)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            row_width_reg <= rdh_pkg::ROW_WIDTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                row_width_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        n_reg     <= n_next;
        words_reg <= words_next;
        widx_reg  <= widx_next;
        v_reg     <= v_next;
        acc_reg   <= acc_next;
        part_reg  <= part_next;
        msel_reg  <= msel_next;
        hash_reg  <= hash_next;
        rem_reg   <= rem_next;
    end

    assign q_item.start_set = start_reg;
    assign q_item.n_words   = n_reg;
    assign q_item.words     = words_reg;
    assign q_slot           = rem_reg[SLOT_W-1:0];

endmodule

FILE: hw/rtl/rdh_fifo.sv
// small queue between hash front end and probe back end
`timescale 1ns / 1ps

module rdh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: hw/rtl/rdh_probe.sv
// back end: linear probing over the slot memory, insert and result register
`timescale 1ns / 1ps

module rdh_probe #(
    parameter int TABLE_SLOTS = 4096,
    parameter int MAX_WORDS   = 4,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  rdh_pkg::item_t        q_item,
    input  logic [SLOT_W-1:0]     q_slot,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    output logic [1:0]            m_tuser
);

    localparam int KEY_W = 32 * MAX_WORDS;
    localparam int ENT_W = rdh_pkg::EPOCH_W + rdh_pkg::ID_W + KEY_W;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_READ  = 2'd2;
    localparam logic [1:0] B_CMP   = 2'd3;

    // each entry: epoch tag, id, key words; a slot is in use when its tag is current
    logic [ENT_W-1:0]             mem [TABLE_SLOTS];
    logic [ENT_W-1:0]             rd_q;

    logic [1:0]                   state_reg;
    logic [rdh_pkg::EPOCH_W-1:0]  epoch_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            probe_reg;
    logic [SLOT_W-1:0]            clr_addr_reg;
    logic                         pend_reg;
    rdh_pkg::row_t                words_reg;
    logic [rdh_pkg::WIDTH_W-1:0]  n_reg;

    logic                         out_valid_reg;
    logic [rdh_pkg::ID_W-1:0]     out_id_reg;
    logic                         out_new_reg;
    logic                         out_ovf_reg;

    logic                         used;
    logic                         match;
    logic                         wr_en;
    logic [SLOT_W-1:0]            wr_addr;
    logic [ENT_W-1:0]             wr_data;
    logic [KEY_W-1:0]             key_in;

    assign clearing = (state_reg == B_CLEAR);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty && (!out_valid_reg || m_tready);
    assign key_in   = words_reg[MAX_WORDS-1:0];
    assign used     = (rd_q[ENT_W-1 -: rdh_pkg::EPOCH_W] == epoch_reg);

    always_comb
    begin
        match = 1'b1;
        for (int j = 0; j < MAX_WORDS; j++)
        begin
            if ((j < int'(n_reg)) && (rd_q[j*32 +: 32] != words_reg[j]))
                match = 1'b0;
        end
    end

    assign wr_en   = clearing || ((state_reg == B_CMP) && !used);
    assign wr_addr = clearing ? clr_addr_reg : slot_reg;
    assign wr_data = clearing ? '0
                   : {epoch_reg, rdh_pkg::ID_W'(count_reg), key_in};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            epoch_reg     <= '0;
            count_reg     <= '0;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == SLOT_W'(TABLE_SLOTS - 1))
                    begin
                        clr_addr_reg <= '0;
                        epoch_reg    <= rdh_pkg::EPOCH_W'(1);
                        pend_reg     <= 1'b0;
                        state_reg    <= pend_reg ? B_READ : B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        words_reg <= q_item.words;
                        n_reg     <= q_item.n_words;
                        slot_reg  <= q_slot;
                        probe_reg <= '0;
                        state_reg <= B_READ;
                        if (q_item.start_set)
                        begin
                            count_reg <= '0;
                            // tag space used up: wipe the table before reuse
                            if (epoch_reg == '1)
                            begin
                                pend_reg  <= 1'b1;
                                state_reg <= B_CLEAR;
                            end
                            else
                                epoch_reg <= epoch_reg + 1'b1;
                        end
                    end
                end
                B_READ:
                    state_reg <= B_CMP;
                default:
                begin
                    if (!used)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= rdh_pkg::ID_W'(count_reg);
                        out_new_reg   <= 1'b1;
                        out_ovf_reg   <= 1'b0;
                        count_reg     <= count_reg + 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else if (match)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= rd_q[KEY_W +: rdh_pkg::ID_W];
                        out_new_reg   <= 1'b0;
                        out_ovf_reg   <= 1'b0;
                        state_reg     <= B_IDLE;
                    end
                    else if (probe_reg == SLOT_W'(TABLE_SLOTS - 1))
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= '0;
                        out_new_reg   <= 1'b0;
                        out_ovf_reg   <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    else
                    begin
                        probe_reg <= probe_reg + 1'b1;
                        slot_reg  <= (slot_reg == SLOT_W'(TABLE_SLOTS - 1)) ? '0
                                   : slot_reg + 1'b1;
                        state_reg <= B_READ;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - rdh_pkg::ID_W){1'b0}}, out_id_reg};
    assign m_tuser  = {out_ovf_reg, out_new_reg};

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_new_reg && out_ovf_reg))
        else $error("result both new and overflow");

    a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |-> (count_reg == CNT_W'(TABLE_SLOTS)))
        else $error("overflow with free slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SLOTS))
        else $error("unique count past table size");

    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("request taken during clear");

endmodule

FILE: hw/rtl/row_dedup_hash_table.sv
// top level of the row dedup hash table
//
//  channel   dir  payload
//  s_*       in   tdata: word0..word3 (32 each); tuser: start_set
//  m_*       out  tdata: entity_id (12, zero padded to 16); tuser: is_new, overflow
//  cfg_*     in   row_width, written when cfg_wr_en is high
//
// hashing: the request is taken, then the mixes (one mix for 2-word rows,
// one per word otherwise) run on a single shared 32x32 multiplier, then slot
// reduction, then queueing
// probing: dequeue, then a registered memory read and a compare per probed slot
// after reset a clear pass over all TABLE_SLOTS slots runs before the first request;
// the same pass repeats on every 255th start_set when the epoch tags run out
// either side may stall; a 2-entry queue and the result register decouple them
`timescale 1ns / 1ps

module row_dedup_hash_table #(
    parameter int TABLE_SLOTS = 4096,
    parameter int MAX_WORDS   = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_wr_data,   // row_width
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,       // word0, word1, word2, word3
    input  logic [0:0]   s_tuser,       // start_set
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,       // entity_id, zero fill
    output logic [1:0]   m_tuser        // is_new, overflow
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int Q_W    = $bits(rdh_pkg::item_t) + SLOT_W;

    logic                 hold;
    logic                 q_push;
    rdh_pkg::item_t       f_item;
    logic [SLOT_W-1:0]    f_slot;
    logic                 q_full;
    logic                 q_pop;
    logic                 q_empty;
    logic [Q_W-1:0]       q_out;
    rdh_pkg::item_t       b_item;
    logic [SLOT_W-1:0]    b_slot;

    rdh_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_WORDS   (MAX_WORDS),
        .SLOT_W      (SLOT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .hold        (hold),
        .q_push      (q_push),
        .q_item      (f_item),
        .q_slot      (f_slot),
        .q_full      (q_full)
    );

    rdh_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_item, f_slot}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign b_item = q_out[Q_W-1:SLOT_W];
    assign b_slot = q_out[SLOT_W-1:0];

    rdh_probe #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .MAX_WORDS   (MAX_WORDS),
        .SLOT_W      (SLOT_W)
    ) u_probe (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (b_item),
        .q_slot   (b_slot),
        .q_pop    (q_pop),
        .clearing (hold),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: test/tb.sv
// testbench for the row dedup hash table: directed rows, random rows, epoch tag wrap
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = 4096;

    typedef struct {
        logic [11:0] id;
        logic        fresh;
        logic        ovf;
    } outcome_t;

    typedef struct {
        int            wcfg;     // -1: leave row width as it is
        logic          st;
        rdh_pkg::row_t row;
        logic          typed;
        outcome_t      res;
    } step_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [2:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;      // word0, word1, word2, word3
    logic [0:0]   s_tuser;      // start_set
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;      // entity_id, zero fill
    logic [1:0]   m_tuser;      // is_new, overflow

    row_dedup_hash_table dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // model of the table contents
    rdh_pkg::row_t key_mem [SLOTS];
    logic [11:0]   id_mem [SLOTS];
    logic          used_mem [SLOTS];
    logic [12:0]   row_count;
    logic [2:0]    width_reg;

    outcome_t      id_expect_q [$];
    outcome_t      typed_q [$];
    logic          typed_flag_q [$];
    rdh_pkg::row_t recent_rows [$];

    int errors;
    int results_seen;
    int new_seen;
    int ovf_seen;
    int starts_sent;
    int send_idle;
    int rx_idle;
    int hold_cnt;
    logic hold_req;
    logic hold_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("timeout at %0t", $time);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        v = v ^ (v >> rdh_pkg::SHIFT_PRE);
        v = v * rdh_pkg::MIX_A;
        v = v ^ (v >> rdh_pkg::SHIFT_MID);
        v = v * rdh_pkg::MIX_B;
        v = v ^ (v >> rdh_pkg::SHIFT_POST);
        return v;
    endfunction

    function automatic int eff_width(input logic [2:0] w);
        if (w < 3'd2)
            return 2;
        if (w > 3'd4)
            return 4;
        return int'(w);
    endfunction

    function automatic logic [11:0] home_slot(input rdh_pkg::row_t r, input int n);
        logic [63:0] h;
        if (n == 2)
            h = splitmix({r[0], r[1]});
        else
        begin
            h = rdh_pkg::GOLDEN;
            for (int j = 0; j < n; j++)
                h = splitmix(h ^ {32'b0, r[j]});
        end
        return h[11:0];
    endfunction

    function automatic outcome_t dedup_row(input logic st, input rdh_pkg::row_t r);
        outcome_t o;
        int n;
        int slot;
        logic same;
        if (st)
        begin
            foreach (used_mem[i])
                used_mem[i] = 1'b0;
            row_count = '0;
        end
        n = eff_width(width_reg);
        slot = int'(home_slot(r, n));
        for (int p = 0; p < SLOTS; p++)
        begin
            if (!used_mem[slot])
            begin
                used_mem[slot] = 1'b1;
                key_mem[slot] = r;
                id_mem[slot] = row_count[11:0];
                o.id = row_count[11:0];
                o.fresh = 1'b1;
                o.ovf = 1'b0;
                row_count++;
                return o;
            end
            same = 1'b1;
            for (int j = 0; j < n; j++)
                if (key_mem[slot][j] != r[j])
                    same = 1'b0;
            if (same)
            begin
                o.id = id_mem[slot];
                o.fresh = 1'b0;
                o.ovf = 1'b0;
                return o;
            end
            slot = (slot + 1) % SLOTS;
        end
        o.id = '0;
        o.fresh = 1'b0;
        o.ovf = 1'b1;
        return o;
    endfunction

    // requests accepted and register writes, in order
    always @(posedge clk)
    begin
        outcome_t o;
        outcome_t t;
        logic tf;
        if (rst_n)
        begin
            if (cfg_wr_en)
                width_reg = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                o = dedup_row(s_tuser[0], s_tdata);
                t = typed_q.pop_front();
                tf = typed_flag_q.pop_front();
                if (tf)
                    id_expect_q.push_back(t);
                else
                    id_expect_q.push_back(o);
            end
        end
    end

    // result checking
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tuser[0])
                new_seen++;
            if (m_tuser[1])
                ovf_seen++;
            if (id_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result id=%0d new=%b ovf=%b", $time,
                         m_tdata[11:0], m_tuser[0], m_tuser[1]);
            end
            else
            begin
                e = id_expect_q.pop_front();
                if (m_tdata[11:0] !== e.id || m_tuser[0] !== e.fresh
                    || m_tuser[1] !== e.ovf)
                begin
                    errors++;
                    $display("%0t: expected id=%0d new=%b ovf=%b, got id=%0d new=%b ovf=%b",
                             $time, e.id, e.fresh, e.ovf, m_tdata[11:0],
                             m_tuser[0], m_tuser[1]);
                end
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= 400)
                hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic send(input logic st, input rdh_pkg::row_t r, input logic typed,
                        input outcome_t res);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        typed_q.push_back(res);
        typed_flag_q.push_back(typed);
        if (st)
            starts_sent++;
        s_tvalid <= 1'b1;
        s_tdata <= r;
        s_tuser <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_row(input logic st, input rdh_pkg::row_t r);
        outcome_t none;
        none = '{default: '0};
        send(st, r, 1'b0, none);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        wait (id_expect_q.size() == 0 && typed_q.size() == 0);
        @(posedge clk);
    endtask

    task automatic write_width(input logic [2:0] w);
        drain();
        repeat (4) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    // mostly rows seen before, so hits and width-dependent matches are common
    function automatic rdh_pkg::row_t pick_row();
        rdh_pkg::row_t r;
        int k;
        for (int j = 0; j < rdh_pkg::IN_WORDS; j++)
            r[j] = rand_word();
        if (recent_rows.size() > 0 && $urandom_range(99) < 55)
        begin
            k = $urandom_range(recent_rows.size() - 1);
            r = (($urandom_range(2) == 0) ? {r[3], r[2], recent_rows[k][1], recent_rows[k][0]}
                                          : recent_rows[k]);
            if ($urandom_range(3) == 0)
                r[3] = rand_word();
        end
        recent_rows.push_back(r);
        if (recent_rows.size() > 48)
            void'(recent_rows.pop_front());
        return r;
    endfunction

    step_t directed [$] = '{
        '{-1, 1'b1, {32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{12'd0, 1'b1, 1'b0}},
        '{-1, 1'b0, {32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{12'd0, 1'b0, 1'b0}},
        '{-1, 1'b0, {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
          1'b1, '{12'd1, 1'b1, 1'b0}},
        // word3 is ignored at width three
        '{-1, 1'b0, {32'hffffffff, 32'h0, 32'h0, 32'h0}, 1'b1, '{12'd0, 1'b0, 1'b0}},
        '{-1, 1'b0, {32'h0, 32'h1, 32'h0, 32'h0}, 1'b1, '{12'd2, 1'b1, 1'b0}},
        '{-1, 1'b0, {32'h4, 32'h3, 32'h2, 32'h1}, 1'b1, '{12'd3, 1'b1, 1'b0}},
        '{-1, 1'b1, {32'h4, 32'h3, 32'h2, 32'h1}, 1'b1, '{12'd0, 1'b1, 1'b0}},
        '{-1, 1'b0, {32'h5, 32'h3, 32'h2, 32'h1}, 1'b1, '{12'd0, 1'b0, 1'b0}},
        // narrower width inside a set compares only the first words
        '{2, 1'b0, {32'h9, 32'h9, 32'h2, 32'h1}, 1'b0, '{12'd0, 1'b0, 1'b0}},
        '{-1, 1'b0, {32'h0, 32'h0, 32'h1, 32'h2}, 1'b0, '{12'd0, 1'b0, 1'b0}},
        '{4, 1'b0, {32'h4, 32'h3, 32'h2, 32'h1}, 1'b0, '{12'd0, 1'b0, 1'b0}},
        '{-1, 1'b0, {32'h4, 32'h3, 32'h2, 32'h1}, 1'b0, '{12'd0, 1'b0, 1'b0}},
        // width below range acts as two
        '{0, 1'b0, {32'h7, 32'h7, 32'h1, 32'h2}, 1'b0, '{12'd0, 1'b0, 1'b0}},
        '{1, 1'b0, {32'h0, 32'h0, 32'h2, 32'h1}, 1'b0, '{12'd0, 1'b0, 1'b0}},
        // width above range acts as four
        '{7, 1'b1, {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
          1'b1, '{12'd0, 1'b1, 1'b0}},
        '{5, 1'b0, {32'h1, 32'h0, 32'h0, 32'h80000000}, 1'b0, '{12'd0, 1'b0, 1'b0}},
        '{6, 1'b0, {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff},
          1'b1, '{12'd0, 1'b0, 1'b0}}
    };

    int idle_tx [3] = '{15, 50, 0};
    int idle_rx [3] = '{50, 15, 0};
    logic [2:0] width_seq [4] = '{3'd2, 3'd3, 3'd4, 3'd0};

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        errors = 0;
        results_seen = 0;
        new_seen = 0;
        ovf_seen = 0;
        starts_sent = 0;
        send_idle = 0;
        rx_idle = 0;
        hold_cnt = 0;
        hold_req = 1'b0;
        hold_done = 1'b0;
        row_count = '0;
        width_reg = rdh_pkg::ROW_WIDTH_RESET;
        foreach (used_mem[i])
            used_mem[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].wcfg >= 0)
                write_width(directed[i].wcfg[2:0]);
            send(directed[i].st, directed[i].row, directed[i].typed, directed[i].res);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = idle_tx[ph];
            rx_idle = idle_rx[ph];
            for (int w = 0; w < 4; w++)
            begin
                write_width((ph == 2 && w == 3) ? 3'd7 : width_seq[(w + ph) % 4]);
                // receiver holds off long enough that the input side backs up
                if (ph == 0 && w == 0)
                begin
                    hold_req = 1'b1;
                    for (int i = 0; i < 12; i++)
                        send_row(1'b0, pick_row());
                    hold_req = 1'b0;
                end
                for (int i = 0; i < 115; i++)
                    send_row($urandom_range(15) == 0, pick_row());
                // sender waits for every result before going on
                if (w == 1)
                    drain();
            end
        end

        // enough set starts to wrap the epoch tags
        write_width(3'd3);
        for (int i = 0; i < 280; i++)
            send_row(1'b1, pick_row());

        s_tvalid <= 1'b0;
        wait (id_expect_q.size() == 0 && typed_q.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d results (%0d new rows, %0d overflows), %0d set starts,",
                 results_seen, new_seen, ovf_seen, starts_sent);
        $display("row widths 0..7, a long receiver hold-off and reuse of the table tags");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rdh_pkg.sv
hw/rtl/rdh_front.sv
hw/rtl/rdh_fifo.sv
hw/rtl/rdh_probe.sv
hw/rtl/row_dedup_hash_table.sv
test/tb.sv
